// ===== rtl/brws_pkg.sv =====
// Package for the biased random walk step block.
// Holds the sequencer state and multiplier operand codes, the control and status
// structs, and the fixed-point and reciprocal constants. No dependencies.
package brws_pkg;

  // Field widths
  localparam int RAND_W = 31;
  localparam int VEL_W  = 18;
  localparam int POS_W  = 18;
  localparam int MAG_W  = 17;   // |position| and |position|^e, at most 1.0
  localparam int EXP_W  = 4;
  localparam int MUL_W  = 32;

  // Exponent clamp (values above act as this)
  localparam logic [EXP_W:0] MAX_EXPONENT = 5'd8;

  // Q16 unit
  localparam logic signed [POS_W+1:0] Q16_ONE  = 20'sd65536;
  localparam logic signed [POS_W+1:0] Q16_MONE = -20'sd65536;
  localparam logic [POS_W-1:0] Q16_ONE_U = 18'd65536;

  // Moduli and their truncated reciprocals (scaled by 2^31 or 2^32)
  localparam logic [MUL_W-1:0] DIR_MOD   = 32'd10000;
  localparam logic [MUL_W-1:0] DIR_RECIP = 32'd214748;   // floor(2^31 / 10000)
  localparam logic [MUL_W-1:0] VEL_MOD   = 32'd1000000;
  localparam logic [MUL_W-1:0] VEL_RECIP = 32'd2147;     // floor(2^31 / 1000000)
  localparam logic [MUL_W-1:0] DIV_LO    = 32'd15625;    // 1000000 / 64
  localparam logic [MUL_W-1:0] DIV_RECIP = 32'd274877;   // floor(2^32 / 15625)

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_POW,
    ST_DQ,
    ST_DR,
    ST_DC,
    ST_VR,
    ST_VC,
    ST_VP,
    ST_VD,
    ST_VQ,
    ST_VM,
    ST_UPD,
    ST_EMIT
  } state_t;

  // Operand selection for the shared multiplier
  typedef enum logic [3:0] {
    OP_NONE,
    OP_POW,   // running power times |position|
    OP_DQ,    // random word times direction reciprocal
    OP_DR,    // direction quotient times 10000
    OP_VQ,    // random word times velocity reciprocal
    OP_VR,    // velocity quotient times 1000000
    OP_VP,    // residue times velocity
    OP_VD,    // scaled product times 1/15625 reciprocal
    OP_VM,    // step quotient times 15625
    OP_BIAS   // (bias + 1.0) times 10000
  } mul_op_t;

  typedef struct packed {
    logic       ready;
    logic       accept;
    mul_op_t    op;
    logic       pow_first;
    logic       cap_pow;
    logic       cap_d;
    logic       cap_rv;
    logic       cap_x6;
    logic       cap_qv;
    logic       cap_mag;
    logic       upd;
    logic       emit;
  } ctrl_t;

  typedef struct packed {
    logic             in_valid;
    logic             out_free;
    logic [EXP_W-1:0] iters;     // multiplies in the power chain
  } stat_t;

endpackage

// ===== rtl/brws_mul.sv =====
// Shared 32x32 unsigned multiplier with a registered product.
// Depends on brws_pkg for the operand width.
module brws_mul (
  input  logic                           clk,
  input  logic [brws_pkg::MUL_W-1:0]     a,
  input  logic [brws_pkg::MUL_W-1:0]     b,
  output logic [2*brws_pkg::MUL_W-1:0]   prod
);

  // One product per cycle, ready the cycle after the operands
  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

// ===== rtl/brws_ctrl.sv =====
// Sequencer for the biased random walk step: walks one request through the
// power chain, the constant divisions and the position update.
// Depends on brws_pkg for state, operand codes and the control structs.
module brws_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  brws_pkg::stat_t     stat,
  output brws_pkg::ctrl_t     ctrl
);

  brws_pkg::state_t                 state, state_next;
  logic [brws_pkg::EXP_W-1:0]       cnt;
  logic                             pow_first;
  logic                             pow_used;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      brws_pkg::ST_IDLE: begin
        if (stat.in_valid) begin
          state_next = (stat.iters == '0) ? brws_pkg::ST_DQ : brws_pkg::ST_POW;
        end
      end
      brws_pkg::ST_POW: begin
        if (cnt == 4'd1) begin
          state_next = brws_pkg::ST_DQ;
        end
      end
      brws_pkg::ST_DQ:  state_next = brws_pkg::ST_DR;
      brws_pkg::ST_DR:  state_next = brws_pkg::ST_DC;
      brws_pkg::ST_DC:  state_next = brws_pkg::ST_VR;
      brws_pkg::ST_VR:  state_next = brws_pkg::ST_VC;
      brws_pkg::ST_VC:  state_next = brws_pkg::ST_VP;
      brws_pkg::ST_VP:  state_next = brws_pkg::ST_VD;
      brws_pkg::ST_VD:  state_next = brws_pkg::ST_VQ;
      brws_pkg::ST_VQ:  state_next = brws_pkg::ST_VM;
      brws_pkg::ST_VM:  state_next = brws_pkg::ST_UPD;
      brws_pkg::ST_UPD: state_next = brws_pkg::ST_EMIT;
      brws_pkg::ST_EMIT: begin
        if (stat.out_free) begin
          state_next = brws_pkg::ST_IDLE;
        end
      end
      default: state_next = brws_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    ctrl           = '0;
    ctrl.op        = brws_pkg::OP_NONE;
    ctrl.pow_first = pow_first;
    case (state)
      brws_pkg::ST_IDLE: begin
        ctrl.ready  = 1'b1;
        ctrl.accept = stat.in_valid;
      end
      brws_pkg::ST_POW: ctrl.op = brws_pkg::OP_POW;
      brws_pkg::ST_DQ: begin
        ctrl.op      = brws_pkg::OP_DQ;
        ctrl.cap_pow = pow_used;
      end
      brws_pkg::ST_DR: ctrl.op = brws_pkg::OP_DR;
      brws_pkg::ST_DC: begin
        ctrl.op    = brws_pkg::OP_VQ;
        ctrl.cap_d = 1'b1;
      end
      brws_pkg::ST_VR: ctrl.op = brws_pkg::OP_VR;
      brws_pkg::ST_VC: ctrl.cap_rv = 1'b1;
      brws_pkg::ST_VP: ctrl.op = brws_pkg::OP_VP;
      brws_pkg::ST_VD: begin
        ctrl.op     = brws_pkg::OP_VD;
        ctrl.cap_x6 = 1'b1;
      end
      brws_pkg::ST_VQ: begin
        ctrl.op     = brws_pkg::OP_VM;
        ctrl.cap_qv = 1'b1;
      end
      brws_pkg::ST_VM: begin
        ctrl.op      = brws_pkg::OP_BIAS;
        ctrl.cap_mag = 1'b1;
      end
      brws_pkg::ST_UPD:  ctrl.upd  = 1'b1;
      brws_pkg::ST_EMIT: ctrl.emit = stat.out_free;
      default: ctrl.op = brws_pkg::OP_NONE;
    endcase
  end

  // State and power-chain counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= brws_pkg::ST_IDLE;
      cnt       <= '0;
      pow_first <= 1'b0;
      pow_used  <= 1'b0;
    end else begin
      state <= state_next;
      if (ctrl.accept) begin
        cnt       <= stat.iters;
        pow_first <= 1'b1;
        pow_used  <= (stat.iters != '0);
      end else if (state == brws_pkg::ST_POW) begin
        cnt       <= cnt - 4'd1;
        pow_first <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/biased_random_walk_step.sv =====
// Biased random walk step: top level with ports, config register and datapath.
// Depends on brws_pkg, brws_mul (shared multiplier) and brws_ctrl (sequencer).
// Requests are handled one at a time (e = clamped exponent) through the single shared
// multiplier: e-1 power steps and eight division and bias products in sequence,
// plus the idle, residue, update and result states; a held result adds its wait.
// No new request is taken until the last result is in the output register.
// Reset: position 0, bias_exponent 1, no result pending; no clearing pass.
module biased_random_walk_step (
  input  logic        clk,
  input  logic        rst,
  // request: [30:0] random_word, [48:31] step_velocity, [55:49] zero
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,
  // result: [17:0] wander_value (signed), [23:18] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,
  // bias_exponent write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_data
);

  brws_pkg::ctrl_t ctrl;
  brws_pkg::stat_t stat;

  logic [brws_pkg::EXP_W-1:0]      bias_exponent;
  logic [brws_pkg::EXP_W:0]        exp_eff;
  logic [brws_pkg::MUL_W-1:0]      mul_a, mul_b;
  logic [2*brws_pkg::MUL_W-1:0]    prod;

  logic signed [brws_pkg::POS_W-1:0] position;
  logic [brws_pkg::RAND_W-1:0]     rand_q;
  logic [brws_pkg::VEL_W-1:0]      vel_q;
  logic [brws_pkg::MAG_W-1:0]      base;
  logic [brws_pkg::MAG_W-1:0]      magp;
  logic                            neg;
  logic [13:0]                     dir_d;
  logic [19:0]                     vel_rv;
  logic [31:0]                     x6;
  logic [17:0]                     qv;
  logic [17:0]                     step_mag;
  logic signed [brws_pkg::POS_W-1:0] wander;
  logic                            out_valid;

  logic [brws_pkg::POS_W-1:0]      pos_neg;
  logic [brws_pkg::POS_W-1:0]      bias_p1;
  logic [30:0]                     dir_diff;
  logic [13:0]                     dir_next;
  logic [20:0]                     vel_diff;
  logic [19:0]                     rv_next;
  logic [31:0]                     div_rem;
  logic [31:0]                     lhs;
  logic signed [19:0]              pos_w, mag_w, pos_dn, pos_up, pos_sel;
  logic signed [brws_pkg::POS_W-1:0] pos_new;

  assign cfg_ready = 1'b1;
  assign s_tready  = ctrl.ready;
  assign m_tvalid  = out_valid;
  assign m_tdata   = {6'b0, wander};

  // Exponent clamp to [1, MAX_EXPONENT]
  always_comb begin
    if (bias_exponent == '0) begin
      exp_eff = 5'd1;
    end else if ({1'b0, bias_exponent} > brws_pkg::MAX_EXPONENT) begin
      exp_eff = brws_pkg::MAX_EXPONENT;
    end else begin
      exp_eff = {1'b0, bias_exponent};
    end
  end

  assign stat.in_valid = s_tvalid;
  assign stat.out_free = !out_valid || m_tready;
  assign stat.iters    = 4'(exp_eff - 5'd1);

  brws_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctrl (ctrl)
  );

  // Operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctrl.op)
      brws_pkg::OP_POW: begin
        mul_a = ctrl.pow_first ? {15'b0, base} : {15'b0, prod[32:16]};
        mul_b = {15'b0, base};
      end
      brws_pkg::OP_DQ: begin
        mul_a = {1'b0, rand_q};
        mul_b = brws_pkg::DIR_RECIP;
      end
      brws_pkg::OP_DR: begin
        mul_a = {14'b0, prod[48:31]};
        mul_b = brws_pkg::DIR_MOD;
      end
      brws_pkg::OP_VQ: begin
        mul_a = {1'b0, rand_q};
        mul_b = brws_pkg::VEL_RECIP;
      end
      brws_pkg::OP_VR: begin
        mul_a = {20'b0, prod[42:31]};
        mul_b = brws_pkg::VEL_MOD;
      end
      brws_pkg::OP_VP: begin
        mul_a = {12'b0, vel_rv};
        mul_b = {14'b0, vel_q};
      end
      brws_pkg::OP_VD: begin
        mul_a = prod[37:6];
        mul_b = brws_pkg::DIV_RECIP;
      end
      brws_pkg::OP_VM: begin
        mul_a = {14'b0, prod[49:32]};
        mul_b = brws_pkg::DIV_LO;
      end
      brws_pkg::OP_BIAS: begin
        mul_a = {14'b0, bias_p1};
        mul_b = brws_pkg::DIR_MOD;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  brws_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // Magnitude of the position and bias + 1.0
  assign pos_neg = 18'(-position);
  assign bias_p1 = neg ? (brws_pkg::Q16_ONE_U - {1'b0, magp})
                       : (brws_pkg::Q16_ONE_U + {1'b0, magp});

  // Residues: quotient estimate is exact or one short, so one correction each
  assign dir_diff = rand_q - prod[30:0];
  assign dir_next = (dir_diff[14:0] >= 15'd10000) ? 14'(dir_diff[14:0] - 15'd10000)
                                                  : dir_diff[13:0];
  assign vel_diff = 21'(rand_q - prod[30:0]);
  assign rv_next  = (vel_diff >= 21'd1000000) ? 20'(vel_diff - 21'd1000000)
                                              : vel_diff[19:0];
  assign div_rem  = x6 - prod[31:0];

  // Direction compare and bounded update
  assign lhs    = {1'b0, dir_d, 17'b0};
  assign pos_w  = 20'(position);
  assign mag_w  = signed'({2'b0, step_mag});
  assign pos_dn = pos_w - mag_w;
  assign pos_up = pos_w + mag_w;

  always_comb begin
    pos_sel = pos_w;
    if (lhs < prod[31:0]) begin
      pos_sel = (pos_dn < brws_pkg::Q16_MONE) ? pos_up : pos_dn;
    end else if (lhs > prod[31:0]) begin
      pos_sel = (pos_up > brws_pkg::Q16_ONE) ? pos_dn : pos_up;
    end
    if (pos_sel > brws_pkg::Q16_ONE) begin
      pos_new = 18'(brws_pkg::Q16_ONE);
    end else if (pos_sel < brws_pkg::Q16_MONE) begin
      pos_new = 18'(brws_pkg::Q16_MONE);
    end else begin
      pos_new = 18'(pos_sel);
    end
  end

  // Control registers: config, position, result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      bias_exponent <= 4'd1;
      position      <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        bias_exponent <= cfg_data;
      end
      if (ctrl.upd) begin
        position <= pos_new;
      end
      if (ctrl.emit) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      rand_q <= s_tdata[30:0];
      vel_q  <= s_tdata[48:31];
      neg    <= position[brws_pkg::POS_W-1];
      base   <= position[brws_pkg::POS_W-1] ? pos_neg[16:0] : position[16:0];
      magp   <= position[brws_pkg::POS_W-1] ? pos_neg[16:0] : position[16:0];
    end
    if (ctrl.cap_pow) begin
      magp <= prod[32:16];
    end
    if (ctrl.cap_d) begin
      dir_d <= dir_next;
    end
    if (ctrl.cap_rv) begin
      vel_rv <= rv_next;
    end
    if (ctrl.cap_x6) begin
      x6 <= prod[37:6];
    end
    if (ctrl.cap_qv) begin
      qv <= prod[49:32];
    end
    if (ctrl.cap_mag) begin
      step_mag <= (div_rem >= brws_pkg::DIV_LO) ? (qv + 18'd1) : qv;
    end
    if (ctrl.emit) begin
      wander <= position;
    end
  end

  // Checks
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("request taken while a step is in progress");

  a_pos_bounded: assert property (@(posedge clk) disable iff (rst)
    (position <= 18'sd65536) && (position >= -18'sd65536))
    else $error("position outside [-1, 1]");

  a_dir_residue: assert property (@(posedge clk) disable iff (rst)
    ctrl.cap_d |=> (dir_d < 14'd10000))
    else $error("direction residue not reduced");

  a_vel_residue: assert property (@(posedge clk) disable iff (rst)
    ctrl.cap_rv |=> (vel_rv < 20'd1000000))
    else $error("velocity residue not reduced");

endmodule

// ===== verif/tb_biased_random_walk_step.sv =====
// Testbench for biased_random_walk_step: drives random-word/velocity requests,
// predicts each wander value in-bench and checks every result in order.
// Depends on the RTL top level and brws_pkg (exponent clamp constant).
`timescale 1ns / 100ps

module tb_biased_random_walk_step;

  localparam int  QUIET_LIMIT  = 5000;   // cycles with no handshake at all
  localparam int  HOLD_CYCLES  = 600;    // long output stall
  localparam int  DRAIN_CYCLES = 40;     // wait after the last result is checked
  localparam longint DIR_MODULUS = 10000;
  localparam longint VEL_MODULUS = 1000000;
  localparam longint UNIT_Q16    = 65536;
  localparam logic [30:0] WORD_MAX = 31'h7FFF_FFFF;
  localparam logic [17:0] VEL_MAX  = 18'h3FFFF;
  localparam logic [17:0] VEL_ONE  = 18'd65536;
  localparam logic [17:0] VEL_TWO  = 18'd131072;
  localparam logic [3:0]  EXP_MIN  = 4'd0;
  localparam logic [3:0]  EXP_ALL  = 4'd15;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata = '0;     // [30:0] random_word, [48:31] step_velocity
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;          // [17:0] wander_value (signed)
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [3:0]  cfg_data = '0;

  // predictor state and expected wander values
  logic signed [17:0] walk_position = '0;
  logic [3:0]         walk_exponent = 4'd1;
  logic signed [17:0] expected_wander[$];

  bit idle_on = 1'b1;
  int error_count = 0;
  int hold_requests = 0;
  int holds_done = 0;
  int rx_hold_left = 0;
  int rx_burst = 0;
  int quiet_cycles = 0;

  biased_random_walk_step u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always #2 clk = ~clk;

  // One walk step: biased direction choice, bound reflection, clamp
  function automatic logic signed [17:0] next_position(input logic signed [17:0] pos,
      input logic [3:0] exp_reg, input logic [30:0] word, input logic [17:0] vel);
    longint power;
    longint base;
    longint pow_mag;
    longint bias;
    longint lhs;
    longint rhs;
    longint stride;
    longint here;
    longint nxt;
    power = (exp_reg == 0) ? 1 :
            ((exp_reg > brws_pkg::MAX_EXPONENT) ? longint'(brws_pkg::MAX_EXPONENT)
                                                : longint'(exp_reg));
    here = longint'(pos);
    base = (here < 0) ? -here : here;
    pow_mag = base;
    for (longint k = 1; k < power; k++) pow_mag = (pow_mag * base) >> 16;
    bias = (here < 0) ? -pow_mag : pow_mag;
    lhs = (longint'(word) % DIR_MODULUS) * 131072;
    rhs = (bias + UNIT_Q16) * DIR_MODULUS;
    stride = ((longint'(word) % VEL_MODULUS) * longint'(vel)) / VEL_MODULUS;
    nxt = here;
    if (lhs < rhs) begin
      nxt = (here - stride < -UNIT_Q16) ? here + stride : here - stride;
    end else if (lhs > rhs) begin
      nxt = (here + stride > UNIT_Q16) ? here - stride : here + stride;
    end
    if (nxt > UNIT_Q16) nxt = UNIT_Q16;
    if (nxt < -UNIT_Q16) nxt = -UNIT_Q16;
    return nxt[17:0];
  endfunction

  // Offer one request, with an optional idle burst first; predict on acceptance
  task automatic send_request(input logic [30:0] word, input logic [17:0] vel);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, vel, word};
    do @(posedge clk); while (!s_tready);
    walk_position = next_position(walk_position, walk_exponent, word, vel);
    expected_wander.push_back(walk_position);
  endtask

  // Stop offering, wait for all results, then let the block go quiet
  task automatic settle_block();
    s_tvalid <= 1'b0;
    while (expected_wander.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_exponent(input logic [3:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    walk_exponent = value;
  endtask

  // Random word: mostly uniform, some edge values and direction ties
  function automatic logic [30:0] pick_word();
    logic [30:0] w;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: w = '0;
          1: w = WORD_MAX;
          2: w = 31'd5000;
          3: w = 31'd999999;
          default: w = 31'd500000;
        endcase
      end
      1: w = 31'(625 * $urandom_range(0, 15) + 10000 * $urandom_range(0, 214747));
      default: w = 31'($urandom_range(0, 32'h7FFF_FFFF));
    endcase
    return w;
  endfunction

  function automatic logic [17:0] pick_velocity();
    logic [17:0] v;
    case ($urandom_range(0, 9))
      0: v = '0;
      1: v = VEL_TWO;
      2: v = 18'($urandom_range(131073, 262143));
      default: v = 18'($urandom_range(0, 131072));
    endcase
    return v;
  endfunction

  // Directed: reset exponent, zero steps, ties at zero and at -1.0, both bounds
  task automatic test_reset_state();
    send_request('0, '0);                  // down by nothing
    send_request(31'd5000, VEL_TWO);       // tie at zero position
    send_request(31'd500000, VEL_TWO);     // down exactly to -1.0
    send_request('0, VEL_MAX);             // tie at -1.0
    send_request(31'd999999, VEL_TWO);     // up from -1.0 to just below +1.0
    send_request(31'd999999, VEL_TWO);     // down from just below +1.0 to -1.0
    send_request(31'd1, VEL_MAX);          // up by nothing at the bottom
    send_request(31'd990000, VEL_TWO);     // tie at -1.0 again, no move
    send_request(WORD_MAX, VEL_MAX);       // all ones, out-of-range velocity
    send_request(31'h4000_0000, VEL_ONE);
    send_request(31'h2AAA_AAAA, 18'h2AAAA);
    send_request(31'h5555_5555, 18'h15555);
    settle_block();
  endtask

  // Every exponent edge: zero, clamp point, all ones, just above clamp
  task automatic test_exponent_range();
    logic [3:0] settings[5];
    settings = '{EXP_MIN, brws_pkg::MAX_EXPONENT[3:0], EXP_ALL, 4'd9, 4'd3};
    foreach (settings[i]) begin
      set_exponent(settings[i]);
      send_request(31'd500000, VEL_ONE);
      send_request(31'd9375, 18'd1000);
      send_request(31'(625 * $urandom_range(0, 15)), pick_velocity());
      send_request(WORD_MAX, VEL_MAX);
      settle_block();
    end
  endtask

  // Long output stall while requests keep coming, so the input backs up
  task automatic test_output_stall();
    hold_requests++;
    repeat (60) send_request(pick_word(), pick_velocity());
    settle_block();
  endtask

  // Random phases, each with its own exponent
  task automatic test_random_walk();
    logic [3:0] value;
    for (int phase = 0; phase < 16; phase++) begin
      value = (phase < 4) ? 4'(phase * 5) : 4'($urandom_range(0, 15));
      set_exponent(value);
      repeat (105) send_request(pick_word(), pick_velocity());
      settle_block();
    end
  endtask

  // Back-to-back traffic with no idling on either side
  task automatic test_steady_stream();
    idle_on = 1'b0;
    set_exponent(brws_pkg::MAX_EXPONENT[3:0]);
    repeat (90) send_request(pick_word(), pick_velocity());
    settle_block();
  endtask

  // Result ready: random stall bursts plus the long hold when requested
  always @(posedge clk) begin
    if (rx_hold_left > 0) begin
      m_tready <= 1'b0;
      rx_hold_left <= rx_hold_left - 1;
    end else if (hold_requests != holds_done) begin
      m_tready <= 1'b0;
      holds_done <= holds_done + 1;
      rx_hold_left <= HOLD_CYCLES;
    end else if (rx_burst > 0) begin
      m_tready <= 1'b0;
      rx_burst <= rx_burst - 1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      m_tready <= 1'b0;
      rx_burst <= $urandom_range(0, 12);
    end else begin
      m_tready <= !rst;
    end
  end

  // Result check against the oldest expected wander value
  always @(posedge clk) begin
    logic signed [17:0] want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_wander.size() == 0) begin
        if (error_count < 10) $display("unexpected result: wander=%0d", $signed(m_tdata[17:0]));
        error_count++;
      end else begin
        want = expected_wander.pop_front();
        if (m_tdata[17:0] !== want) begin
          if (error_count < 10)
            $display("wander mismatch: expected %0d, got %0d", want, $signed(m_tdata[17:0]));
          error_count++;
        end
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL biased_random_walk_step");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_exponent_range();
    test_output_stall();
    test_random_walk();
    test_steady_stream();
    if (error_count == 0 && expected_wander.size() == 0) begin
      $display("PASS biased_random_walk_step");
    end else begin
      $display("FAIL biased_random_walk_step");
    end
    $finish;
  end

endmodule
